@@ hdl/brc_pkg.sv @@
// Package with the shared types and constants of the circle rasterizer.
`timescale 1ns / 1ps

package brc_pkg;

    // Coordinate width and the widths derived from it
    localparam int COORD_BITS = 10;
    localparam int OFF_BITS   = COORD_BITS + 2;
    localparam int DEC_BITS   = COORD_BITS + 6;
    localparam int PIX_BITS   = COORD_BITS + 2;

    // Command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Eight mirrored pixels per point
    localparam int         PHASE_BITS = 3;
    localparam logic [2:0] LAST_PHASE = 3'd7;

    // Decision update constants
    localparam int DEC_INIT   = 3;
    localparam int DEC_DIAG   = 10;
    localparam int DEC_STRAIT = 6;

    // Input transaction
    typedef struct packed {
        logic                  command;
        logic [COORD_BITS-1:0] centre_x;
        logic [COORD_BITS-1:0] centre_y;
        logic [COORD_BITS-1:0] radius;
    } brc_cmd_t;

    // Output transaction
    typedef struct packed {
        logic signed [PIX_BITS-1:0] pixel_x;
        logic signed [PIX_BITS-1:0] pixel_y;
        logic                       done_res;
    } brc_pix_t;

    // One rasterized point, passed from front to back
    typedef struct packed {
        logic [COORD_BITS-1:0]      cx;
        logic [COORD_BITS-1:0]      cy;
        logic signed [OFF_BITS-1:0] x;
        logic signed [OFF_BITS-1:0] y;
        logic                       done;
    } brc_point_t;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } brc_qstat_t;

endpackage

@@ hdl/brc_front.sv @@
// Front end: accepts commands, runs the midpoint recurrence, pushes points.
`timescale 1ns / 1ps

module brc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  brc_pkg::brc_cmd_t   cmd,
    input  logic                q_full,
    output logic                q_push,
    output brc_pkg::brc_point_t q_data
);
    import brc_pkg::*;

    logic [COORD_BITS-1:0]      centre_col_reg, centre_col_next;
    logic [COORD_BITS-1:0]      centre_row_reg, centre_row_next;
    logic signed [OFF_BITS-1:0] offset_a_reg, offset_a_next;
    logic signed [OFF_BITS-1:0] offset_b_reg, offset_b_next;
    logic signed [DEC_BITS-1:0] decision_reg, decision_next;
    logic                       busy_reg, busy_next;

    logic                       accept;
    logic                       is_start;
    logic signed [OFF_BITS-1:0] step_a;
    logic signed [OFF_BITS-1:0] step_b;
    logic signed [DEC_BITS-1:0] step_a_ext;
    logic signed [DEC_BITS-1:0] step_b_ext;
    logic signed [DEC_BITS-1:0] step_dec;
    logic signed [DEC_BITS-1:0] radius_ext;
    logic                       step_done;

    // Stall whenever the point queue cannot take another entry
    assign cmd_stall = q_full;
    assign accept    = cmd_valid && !q_full;
    assign is_start  = (cmd.command == CMD_START);

    // Next point of the recurrence
    always_comb
    begin
        step_a     = offset_a_reg + OFF_BITS'(1);
        step_b     = offset_b_reg;
        step_a_ext = {{(DEC_BITS-OFF_BITS){step_a[OFF_BITS-1]}}, step_a};
        step_b_ext = {{(DEC_BITS-OFF_BITS){step_b[OFF_BITS-1]}}, step_b};
        if (decision_reg > 0)
        begin
            step_b     = offset_b_reg - OFF_BITS'(1);
            step_b_ext = {{(DEC_BITS-OFF_BITS){step_b[OFF_BITS-1]}}, step_b};
            step_dec   = decision_reg + ((step_a_ext - step_b_ext) <<< 2)
                         + DEC_BITS'(DEC_DIAG);
        end
        else
        begin
            step_dec = decision_reg + (step_a_ext <<< 2) + DEC_BITS'(DEC_STRAIT);
        end
        step_done = (step_a > step_b);
    end

    assign radius_ext = {{(DEC_BITS-COORD_BITS){1'b0}}, cmd.radius};

    // Update circle state on an accepted start, or an accepted step of a running circle
    always_comb
    begin
        centre_col_next = centre_col_reg;
        centre_row_next = centre_row_reg;
        offset_a_next   = offset_a_reg;
        offset_b_next   = offset_b_reg;
        decision_next   = decision_reg;
        busy_next       = busy_reg;
        if (accept)
        begin
            if (is_start)
            begin
                centre_col_next = cmd.centre_x;
                centre_row_next = cmd.centre_y;
                offset_a_next   = '0;
                offset_b_next   = {{(OFF_BITS-COORD_BITS){1'b0}}, cmd.radius};
                decision_next   = DEC_BITS'(DEC_INIT) - (radius_ext <<< 1);
                busy_next       = 1'b1;
            end
            else if (busy_reg)
            begin
                offset_a_next = step_a;
                offset_b_next = step_b;
                decision_next = step_dec;
                busy_next     = !step_done;
            end
        end
    end

    // Push a point for a start, or for a step of a running circle
    assign q_push      = accept && (is_start || busy_reg);
    assign q_data.cx   = centre_col_next;
    assign q_data.cy   = centre_row_next;
    assign q_data.x    = offset_a_next;
    assign q_data.y    = offset_b_next;
    assign q_data.done = !is_start && step_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_col_reg <= '0;
            centre_row_reg <= '0;
            offset_a_reg   <= '0;
            offset_b_reg   <= '0;
            decision_reg   <= '0;
            busy_reg       <= 1'b0;
        end
        else
        begin
            centre_col_reg <= centre_col_next;
            centre_row_reg <= centre_row_next;
            offset_a_reg   <= offset_a_next;
            offset_b_reg   <= offset_b_next;
            decision_reg   <= decision_next;
            busy_reg       <= busy_next;
        end
    end

endmodule

@@ hdl/brc_queue.sv @@
// Two-entry point queue between front and back.
`timescale 1ns / 1ps

module brc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  brc_pkg::brc_point_t push_data,
    input  logic                pop,
    output brc_pkg::brc_point_t pop_data,
    output brc_pkg::brc_qstat_t stat
);
    import brc_pkg::*;

    brc_point_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/brc_back.sv @@
// Back end: expands each point into its eight mirrored pixels.
`timescale 1ns / 1ps

module brc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pt_valid,
    input  brc_pkg::brc_point_t pt,
    output logic                pop,
    output logic                pix_valid,
    input  logic                pix_stall,
    output brc_pkg::brc_pix_t   pix
);
    import brc_pkg::*;

    brc_point_t            cur_reg, cur_next;
    logic                  cur_valid_reg, cur_valid_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    brc_pix_t              out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic                       slot_free;
    logic                       emit;
    logic                       last;
    logic signed [PIX_BITS-1:0] cx_ext;
    logic signed [PIX_BITS-1:0] cy_ext;
    logic signed [PIX_BITS-1:0] dx;
    logic signed [PIX_BITS-1:0] dy;

    assign slot_free = !out_valid_reg || !pix_stall;
    assign emit      = cur_valid_reg && slot_free;
    assign last      = emit && (phase_reg == LAST_PHASE);
    assign pop       = pt_valid && (!cur_valid_reg || last);

    // Select offsets and signs for the current octant
    always_comb
    begin
        cx_ext = {{(PIX_BITS-COORD_BITS){1'b0}}, cur_reg.cx};
        cy_ext = {{(PIX_BITS-COORD_BITS){1'b0}}, cur_reg.cy};
        dx     = phase_reg[2] ? PIX_BITS'(cur_reg.y) : PIX_BITS'(cur_reg.x);
        dy     = phase_reg[2] ? PIX_BITS'(cur_reg.x) : PIX_BITS'(cur_reg.y);
        out_next          = out_reg;
        out_next.pixel_x  = phase_reg[0] ? (cx_ext - dx) : (cx_ext + dx);
        out_next.pixel_y  = phase_reg[1] ? (cy_ext - dy) : (cy_ext + dy);
        out_next.done_res = cur_reg.done && (phase_reg == LAST_PHASE);
    end

    // Sequence points and the output register
    always_comb
    begin
        cur_next       = pop ? pt : cur_reg;
        cur_valid_next = cur_valid_reg;
        phase_next     = phase_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            phase_next     = '0;
        end
        else if (last)
        begin
            cur_valid_next = 1'b0;
        end
        else if (emit)
        begin
            phase_next = phase_reg + PHASE_BITS'(1);
        end
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!pix_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    assign pix_valid = out_valid_reg;
    assign pix       = out_reg;

endmodule

@@ hdl/bresenham_circle_rasterizer.sv @@
// Top level of the midpoint circle rasterizer.
//
// Command channel (cmd_valid / cmd_stall / cmd): a start transaction loads
// centre and radius and yields the eight pixels of the first point; a step
// transaction advances one point and yields eight pixels. A step while no
// circle runs is consumed and yields nothing.
// Pixel channel (pix_valid / pix_stall / pix): one pixel per transaction,
// done_res set on the final pixel of a circle.
// A point passes through a queue entry and the current-point register of
// the back end before its first pixel reaches the output register.
// Throughput is set by the single pixel output register of the back end,
// which passes the eight pixels of each point in turn; the front runs ahead
// by up to three points (two queue entries plus the one being expanded).
// When the receiver stalls, the output holds its pixel, the back end stops,
// the queue fills and then cmd_stall rises.
// Reset (rst_n low, asynchronous) drops any circle and empties the queue.
`timescale 1ns / 1ps

module bresenham_circle_rasterizer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  brc_pkg::brc_cmd_t cmd,
    output logic              pix_valid,
    input  logic              pix_stall,
    output brc_pkg::brc_pix_t pix
);
    import brc_pkg::*;

    logic       q_push;
    logic       q_pop;
    brc_point_t q_in;
    brc_point_t q_out;
    brc_qstat_t q_stat;

    brc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_full    (q_stat.full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    brc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .stat      (q_stat)
    );

    brc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt_valid  (!q_stat.empty),
        .pt        (q_out),
        .pop       (q_pop),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix)
    );

    // Never write into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_stat.full))
        else $error("point queue overflow");

    // Never read from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) !(q_pop && q_stat.empty))
        else $error("point queue underflow");

    // A filled queue with a free output keeps pixels flowing
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.full && !pix_stall) |=> pix_valid)
        else $error("back end idle while points are waiting");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the midpoint circle rasterizer: directed table, then random circles.
`timescale 1ns / 1ps

module testbench;

    import brc_pkg::*;

    localparam int ITEMS      = 500;
    localparam int MAX_WAIT   = 8;
    localparam int TAIL       = 40;
    localparam int LIMIT      = 600000;
    localparam int REPORT_MAX = 10;

    // How a directed row gets its expected pixels
    typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_SAME} row_kind_t;

    typedef struct packed {
        brc_cmd_t                   item;
        row_kind_t                  kind;
        logic signed [PIX_BITS-1:0] px;
        logic signed [PIX_BITS-1:0] py;
    } steer_row_t;

    logic     clk;
    logic     rst_n;
    logic     cmd_valid;
    logic     cmd_stall;
    brc_cmd_t cmd;
    logic     pix_valid;
    logic     pix_stall = 1'b0;
    brc_pix_t pix;

    // Circle state tracked alongside the block
    logic [COORD_BITS-1:0]      trk_cx;
    logic [COORD_BITS-1:0]      trk_cy;
    logic signed [OFF_BITS-1:0] trk_x;
    logic signed [OFF_BITS-1:0] trk_y;
    logic signed [DEC_BITS-1:0] trk_dec;
    logic                       trk_busy;

    brc_pix_t   pixels_due[$];
    steer_row_t steer_rows[$];
    brc_pix_t   pix_want;

    int  cycles        = 0;
    int  mismatches    = 0;
    int  pixels_seen   = 0;
    int  dones_seen    = 0;
    int  starts_sent   = 0;
    int  steps_sent    = 0;
    int  drawing_items = 0;
    int  stall_left    = 0;
    bit  rx_burst      = 1'b0;
    bit  tx_burst      = 1'b0;

    bresenham_circle_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixels still pending",
                     cycles, pixels_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Log one failure; print only the first few
    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    // Advance the tracked circle by one command; fill pts and return the pixel count
    function automatic int trace_point(input brc_cmd_t c, output brc_pix_t pts[8]);
        int cx;
        int cy;
        int ox;
        int oy;
        int sx;
        int sy;
        foreach (pts[k])
            pts[k] = '0;
        if (c.command == CMD_START)
        begin
            trk_cx   = c.centre_x;
            trk_cy   = c.centre_y;
            trk_x    = '0;
            trk_y    = OFF_BITS'(int'(c.radius));
            trk_dec  = DEC_BITS'(DEC_INIT - 2 * int'(c.radius));
            trk_busy = 1'b1;
        end
        else if (!trk_busy)
        begin
            return 0;
        end
        else
        begin
            // Step x; take the diagonal move when the decision value is positive
            trk_x = OFF_BITS'(int'(trk_x) + 1);
            if (trk_dec > 0)
            begin
                trk_y   = OFF_BITS'(int'(trk_y) - 1);
                trk_dec = DEC_BITS'(int'(trk_dec) + 4 * (int'(trk_x) - int'(trk_y)) + DEC_DIAG);
            end
            else
            begin
                trk_dec = DEC_BITS'(int'(trk_dec) + 4 * int'(trk_x) + DEC_STRAIT);
            end
        end
        cx = int'(trk_cx);
        cy = int'(trk_cy);
        ox = int'(trk_x);
        oy = int'(trk_y);
        // Mirror into the eight octants: sign of x alternates, sign of y every pair
        for (int k = 0; k < 4; k++)
        begin
            sx = (k % 2 == 1) ? -1 : 1;
            sy = (k / 2 == 1) ? -1 : 1;
            pts[k].pixel_x     = PIX_BITS'(cx + sx * ox);
            pts[k].pixel_y     = PIX_BITS'(cy + sy * oy);
            pts[k + 4].pixel_x = PIX_BITS'(cx + sx * oy);
            pts[k + 4].pixel_y = PIX_BITS'(cy + sy * ox);
        end
        // Finish the circle once x passes y
        if (c.command == CMD_STEP && trk_x > trk_y)
        begin
            pts[7].done_res = 1'b1;
            trk_busy        = 1'b0;
        end
        return 8;
    endfunction

    function automatic brc_cmd_t rand_item(input logic code, input int r_lo, input int r_hi);
        brc_cmd_t c;
        c.command  = code;
        c.centre_x = COORD_BITS'($urandom_range(0, 1023));
        c.centre_y = COORD_BITS'($urandom_range(0, 1023));
        c.radius   = COORD_BITS'($urandom_range(r_hi, r_lo));
        return c;
    endfunction

    task automatic add_row(input logic code, input int cx, input int cy, input int r,
                           input row_kind_t kind, input int px = 0, input int py = 0);
        steer_row_t row;
        row.item.command  = code;
        row.item.centre_x = COORD_BITS'(cx);
        row.item.centre_y = COORD_BITS'(cy);
        row.item.radius   = COORD_BITS'(r);
        row.kind          = kind;
        row.px            = PIX_BITS'(px);
        row.py            = PIX_BITS'(py);
        steer_rows.push_back(row);
    endtask

    // Drive one command transaction and queue the pixels it should yield
    task automatic send_item(input brc_cmd_t c, input row_kind_t kind,
                             input logic signed [PIX_BITS-1:0] px,
                             input logic signed [PIX_BITS-1:0] py);
        brc_pix_t pts[8];
        brc_pix_t same;
        int       gap;
        int       n;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        // Transaction taken at this edge
        n = trace_point(c, pts);
        if (kind == ROW_PREDICT)
        begin
            for (int k = 0; k < n; k++)
                pixels_due.push_back(pts[k]);
        end
        else if (kind == ROW_SAME)
        begin
            same.pixel_x  = px;
            same.pixel_y  = py;
            same.done_res = 1'b0;
            repeat (8) pixels_due.push_back(same);
        end
        if (c.command == CMD_START)
            starts_sent++;
        else
            steps_sent++;
        if (n > 0)
            drawing_items++;
    endtask

    // Check each pixel transaction and draw the next receiver stall
    always @(posedge clk)
    begin
        if (rst_n && pix_valid && !pix_stall)
        begin
            pixels_seen++;
            if (pix.done_res)
                dones_seen++;
            if (pixels_due.size() == 0)
            begin
                note_error($sformatf("pixel (%0d, %0d) done=%0b with nothing pending",
                                     pix.pixel_x, pix.pixel_y, pix.done_res));
            end
            else
            begin
                pix_want = pixels_due.pop_front();
                if (pix.pixel_x !== pix_want.pixel_x)
                    note_error($sformatf("pixel_x expected %0d, got %0d",
                                         pix_want.pixel_x, pix.pixel_x));
                if (pix.pixel_y !== pix_want.pixel_y)
                    note_error($sformatf("pixel_y expected %0d, got %0d",
                                         pix_want.pixel_y, pix.pixel_y));
                if (pix.done_res !== pix_want.done_res)
                    note_error($sformatf("done_res expected %0b, got %0b at (%0d, %0d)",
                                         pix_want.done_res, pix.done_res,
                                         pix_want.pixel_x, pix_want.pixel_y));
            end
            stall_left = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if ($urandom_range(0, 63) == 0)
                rx_burst = !rx_burst;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
        end
        pix_stall <= (stall_left != 0);
    end

    initial
    begin
        int pick;
        int r;
        int cap;
        int n;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        trk_cx   = '0;
        trk_cy   = '0;
        trk_x    = '0;
        trk_y    = '0;
        trk_dec  = '0;
        trk_busy = 1'b0;

        // Directed table: idle step, zero radius, full-range centres and radius,
        // start over a running circle, alternating bit patterns
        add_row(CMD_STEP,     0,    0,    0, ROW_NONE);
        add_row(CMD_START,    0,    0,    0, ROW_SAME, 0, 0);
        add_row(CMD_STEP,     0,    0,    0, ROW_PREDICT);
        add_row(CMD_STEP,  1023, 1023, 1023, ROW_NONE);
        add_row(CMD_START, 1023, 1023,    0, ROW_SAME, 1023, 1023);
        add_row(CMD_START, 1023, 1023, 1023, ROW_PREDICT);
        add_row(CMD_STEP,     0,    0,    0, ROW_PREDICT);
        add_row(CMD_STEP,  1023, 1023, 1023, ROW_PREDICT);
        add_row(CMD_START,    0,    0, 1023, ROW_PREDICT);
        add_row(CMD_STEP,   341,  682,  341, ROW_PREDICT);
        add_row(CMD_START,  512,  512,    1, ROW_PREDICT);
        add_row(CMD_STEP,   512,  512,    1, ROW_PREDICT);
        add_row(CMD_STEP,   512,  512,    1, ROW_NONE);
        add_row(CMD_START,  341,  682,    5, ROW_PREDICT);
        add_row(CMD_STEP,   682,  341,  682, ROW_PREDICT);
        add_row(CMD_STEP,   682,  341,  682, ROW_PREDICT);
        add_row(CMD_STEP,   682,  341,  682, ROW_PREDICT);
        add_row(CMD_STEP,   682,  341,  682, ROW_PREDICT);
        add_row(CMD_STEP,   682,  341,  682, ROW_PREDICT);
        add_row(CMD_START,  682,  341,  682, ROW_PREDICT);
        add_row(CMD_STEP,     0,    0,    0, ROW_PREDICT);
        add_row(CMD_START, 1023,    0,    2, ROW_PREDICT);
        add_row(CMD_STEP,     0, 1023,    0, ROW_PREDICT);
        add_row(CMD_STEP,     0, 1023,    0, ROW_PREDICT);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steer_rows[i])
            send_item(steer_rows[i].item, steer_rows[i].kind, steer_rows[i].px, steer_rows[i].py);

        // Random circles, mostly small, stepped to the end; some cut short or noisy
        while (drawing_items < ITEMS)
        begin
            tx_burst = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                send_item(rand_item(CMD_STEP, 0, 1023), ROW_PREDICT, '0, '0);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    r = $urandom_range(0, 40);
                else if (pick < 95)
                    r = $urandom_range(41, 200);
                else
                    r = $urandom_range(201, 1023);
                send_item(rand_item(CMD_START, r, r), ROW_PREDICT, '0, '0);
                if ($urandom_range(0, 4) == 0)
                    cap = $urandom_range(0, 8);
                else
                    cap = (r > 200) ? 60 : 1000;
                n = 0;
                while (trk_busy && n < cap)
                begin
                    send_item(rand_item(CMD_STEP, 0, 1023), ROW_PREDICT, '0, '0);
                    n++;
                end
                if ($urandom_range(0, 3) == 0)
                    send_item(rand_item(CMD_STEP, 0, 1023), ROW_PREDICT, '0, '0);
            end
        end
        cmd_valid <= 1'b0;

        // Drain, then give stray pixels time to show up
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);

        $display("covered %0d start and %0d step commands, %0d of them drawing",
                 starts_sent, steps_sent, drawing_items);
        $display("checked %0d pixels, %0d circles closed, %0d errors",
                 pixels_seen, dones_seen, mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
